@@ hdl/resampling_voice_mixer_unit_assert.svh @@
// assertion macros shared by the voice mixer
`ifndef RESAMPLING_VOICE_MIXER_UNIT_ASSERT_SVH
`define RESAMPLING_VOICE_MIXER_UNIT_ASSERT_SVH

// cond and expr in the same cycle
`define RVM_ASSERT_NOW(label, clk, rst_n, cond, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
    else $error("voice mixer assertion failed");

// expr in the cycle after cond
`define RVM_ASSERT_NEXT(label, clk, rst_n, cond, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
    else $error("voice mixer assertion failed");

`endif

@@ hdl/rvm_pkg.sv @@
package rvm_pkg;

  localparam int RVM_SAMPLE_DEPTH = 65536;
  localparam int RVM_FRAC_BITS    = 16;
  localparam int STEP_W           = 24;
  localparam int CFG_DATA_W       = 24;

  localparam logic [16:0] UNITY_GAIN = 17'h10000;
  localparam logic signed [7:0] PAN_LIMIT = 8'sd100;

  // func codes of an input word
  localparam logic [2:0] FUNC_WRITE = 3'd0;
  localparam logic [2:0] FUNC_FRAME = 3'd1;
  localparam logic [2:0] FUNC_START = 3'd2;
  localparam logic [2:0] FUNC_STOP  = 3'd3;
  localparam logic [2:0] FUNC_SEEK  = 3'd4;

  // configuration register indexes
  localparam logic [1:0] CFG_STEP_RATE = 2'd0;
  localparam logic [1:0] CFG_VOLUME    = 2'd1;
  localparam logic [1:0] CFG_PAN       = 2'd2;
  localparam logic [1:0] CFG_LENGTH    = 2'd3;

  typedef struct packed {
    logic [2:0]         func;
    logic [15:0]        sample_address;
    logic signed [15:0] sample_value;
    logic [15:0]        seek_position;
    logic signed [15:0] mix_in_left;
    logic signed [15:0] mix_in_right;
    logic               freeze;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] mix_out_left;
    logic signed [15:0] mix_out_right;
    logic               is_playing;
    logic [16:0]        position_index;
  } out_item_t;

  typedef enum logic [2:0] {
    CMD_NOP,
    CMD_WRITE,
    CMD_FRAME,
    CMD_START,
    CMD_STOP,
    CMD_SEEK
  } cmd_e;

  typedef struct packed {
    cmd_e               cmd;
    logic [15:0]        sample_address;
    logic signed [15:0] sample_value;
    logic [15:0]        seek_position;
    logic signed [15:0] mix_in_left;
    logic signed [15:0] mix_in_right;
  } cmd_item_t;

  typedef struct packed {
    logic pop;
    logic busy;
  } bk_status_t;

  typedef struct packed {
    logic [STEP_W-1:0] step_rate;
    logic [16:0]       volume;
    logic [16:0]       gain;
    logic              far_left;
  } voice_cfg_t;

  typedef logic [16:0] gain_table_t [0:100];

  // far side gain in Q1.16 for each pan magnitude
  function automatic gain_table_t build_gain_table();
    gain_table_t t;
    for (int i = 0; i <= 100; i++) begin
      t[i] = 17'(((100 - i) * 65536) / 100);
    end
    return t;
  endfunction

  localparam gain_table_t GAIN_TABLE = build_gain_table();

endpackage

@@ hdl/rvm_ram.sv @@
module rvm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256,
  localparam int AddrW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ hdl/rvm_front.sv @@
module rvm_front #(
  parameter int SAMPLE_DEPTH = rvm_pkg::RVM_SAMPLE_DEPTH
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  rvm_pkg::in_item_t   in_data_i,
  input  rvm_pkg::bk_status_t status_i,
  output logic                q_valid_o,
  output rvm_pkg::cmd_item_t  q_item_o
);
  import rvm_pkg::*;

  localparam int QDepth = 2;

  cmd_item_t  ent_q [QDepth];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       push;
  cmd_item_t  cls;

  assign in_stall_o = (cnt_q == 2'(QDepth));
  assign push       = in_valid_i && !in_stall_o;
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_item_o   = ent_q[rd_ptr_q];

  // decode func into a command for the back end
  always_comb begin
    cls.sample_address = in_data_i.sample_address;
    cls.sample_value   = in_data_i.sample_value;
    cls.seek_position  = in_data_i.seek_position;
    cls.mix_in_left    = in_data_i.mix_in_left;
    cls.mix_in_right   = in_data_i.mix_in_right;
    case (in_data_i.func)
      FUNC_WRITE: begin
        cls.cmd = (32'(in_data_i.sample_address) < 32'(SAMPLE_DEPTH)) ? CMD_WRITE : CMD_NOP;
      end
      FUNC_FRAME: cls.cmd = in_data_i.freeze ? CMD_NOP : CMD_FRAME;
      FUNC_START: cls.cmd = CMD_START;
      FUNC_STOP:  cls.cmd = CMD_STOP;
      FUNC_SEEK:  cls.cmd = CMD_SEEK;
      default:    cls.cmd = CMD_NOP;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (status_i.pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      cnt_q <= cnt_q + 2'(push) - 2'(status_i.pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      ent_q[wr_ptr_q] <= cls;
    end
  end

endmodule

@@ hdl/rvm_back.sv @@
module rvm_back #(
  parameter int SAMPLE_DEPTH = rvm_pkg::RVM_SAMPLE_DEPTH,
  parameter int FRAC_BITS    = rvm_pkg::RVM_FRAC_BITS,
  localparam int LenW = $clog2(SAMPLE_DEPTH + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_valid_i,
  input  rvm_pkg::cmd_item_t  q_item_i,
  output rvm_pkg::bk_status_t status_o,
  input  rvm_pkg::voice_cfg_t cfg_i,
  input  logic [LenW-1:0]     eff_len_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output rvm_pkg::out_item_t  out_data_o
);
  import rvm_pkg::*;

  localparam int AddrW    = $clog2(SAMPLE_DEPTH);
  localparam int StepInt  = (FRAC_BITS >= STEP_W) ? 0 : (1 << (STEP_W - FRAC_BITS));
  localparam int IntW     = $clog2(SAMPLE_DEPTH + StepInt + 1);
  localparam int PosW     = IntW + FRAC_BITS;
  localparam int CmpW     = (IntW > 16) ? IntW : 16;
  localparam int InterpW  = 34;
  localparam int VprodW   = InterpW + 18;
  localparam int BaseW    = 17;
  localparam int GprodW   = BaseW + 18;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ1,
    ST_INTERP,
    ST_VOL,
    ST_BASE,
    ST_PAN,
    ST_FINISH
  } state_e;

  function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
    if (v > 18'sd32767) begin
      return 16'sh7fff;
    end else if (v < -18'sd32768) begin
      return 16'sh8000;
    end
    return v[15:0];
  endfunction

  state_e                     state_q, state_d;
  logic [PosW-1:0]            pos_q, pos_d;
  logic                       play_q, play_d;
  logic                       out_valid_q;
  out_item_t                  out_q, out_d;
  logic                       load;
  logic                       out_free, pop;
  logic signed [15:0]         mix_l, mix_r;

  cmd_item_t                  cur_q;
  logic [AddrW-1:0]           i1_q;
  logic signed [15:0]         s0_q;
  logic signed [InterpW-1:0]  interp_q, interp_d;
  logic signed [VprodW-1:0]   vprod_q, vsum;
  logic signed [BaseW-1:0]    base_q, far;
  logic signed [BaseW-1:0]    add_l, add_r;
  logic signed [GprodW-1:0]   gprod_q, gsum;

  logic [IntW-1:0]            pos_int, len_ext, i1_inc, i1_next;
  logic [15:0]                frac16;
  logic signed [16:0]         diff, frac_s;
  logic signed [InterpW-1:0]  mprod;
  logic signed [17:0]         vol_s, gain_s;
  logic signed [17:0]         sum_l, sum_r;

  logic                       ram_we;
  logic [AddrW-1:0]           ram_waddr, ram_raddr;
  logic [15:0]                ram_rdata;

  rvm_ram #(
    .WIDTH (16),
    .DEPTH (SAMPLE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (q_item_i.sample_value),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  generate
    if (FRAC_BITS >= 16) begin : g_frac_wide
      assign frac16 = pos_q[FRAC_BITS-1 -: 16];
    end else begin : g_frac_narrow
      assign frac16 = {pos_q[FRAC_BITS-1:0], {(16 - FRAC_BITS){1'b0}}};
    end
  endgenerate

  assign pos_int = pos_q[PosW-1:FRAC_BITS];
  assign len_ext = IntW'(eff_len_i);
  assign i1_inc  = pos_int + IntW'(1);
  // second tap clamps to the last valid sample
  assign i1_next = (i1_inc >= len_ext) ? (len_ext - IntW'(1)) : i1_inc;

  assign out_free = !out_valid_q || !out_stall_i;
  assign pop      = (state_q == ST_IDLE) && q_valid_i && out_free;

  assign status_o.pop  = pop;
  assign status_o.busy = (state_q != ST_IDLE);

  assign ram_waddr = AddrW'(q_item_i.sample_address);
  assign ram_raddr = (state_q == ST_READ1) ? i1_q : AddrW'(pos_int);

  // datapath: s0*65536 + (s1 - s0)*f equals the two-tap blend exactly
  assign diff     = $signed({ram_rdata[15], ram_rdata}) - $signed({s0_q[15], s0_q});
  assign frac_s   = $signed({1'b0, frac16});
  assign mprod    = diff * frac_s;
  assign interp_d = mprod + $signed({{2{s0_q[15]}}, s0_q, 16'h0000});
  assign vol_s    = $signed({1'b0, cfg_i.volume});
  assign gain_s   = $signed({1'b0, cfg_i.gain});

  // truncate toward zero: bias negatives before the arithmetic shift
  assign vsum = vprod_q + $signed({{(VprodW-32){1'b0}}, {32{vprod_q[VprodW-1]}}});
  assign gsum = gprod_q + $signed({{(GprodW-16){1'b0}}, {16{gprod_q[GprodW-1]}}});
  assign far  = gsum[16 +: BaseW];

  assign add_l = cfg_i.far_left ? far : base_q;
  assign add_r = cfg_i.far_left ? base_q : far;

  assign sum_l = $signed({{2{cur_q.mix_in_left[15]}}, cur_q.mix_in_left})
               + $signed({add_l[BaseW-1], add_l});
  assign sum_r = $signed({{2{cur_q.mix_in_right[15]}}, cur_q.mix_in_right})
               + $signed({add_r[BaseW-1], add_r});

  always_comb begin
    state_d = state_q;
    pos_d   = pos_q;
    play_d  = play_q;
    load    = 1'b0;
    ram_we  = 1'b0;
    mix_l   = q_item_i.mix_in_left;
    mix_r   = q_item_i.mix_in_right;
    case (state_q)
      ST_IDLE: begin
        if (pop) begin
          load = 1'b1;
          case (q_item_i.cmd)
            CMD_WRITE: ram_we = 1'b1;
            CMD_FRAME: begin
              if (play_q && (pos_int < len_ext)) begin
                load    = 1'b0;
                state_d = ST_READ1;
              end else if (play_q) begin
                // end of sound: stop and rewind
                play_d = 1'b0;
                pos_d  = '0;
              end
            end
            CMD_START: begin
              play_d = 1'b1;
              pos_d  = '0;
            end
            CMD_STOP: play_d = 1'b0;
            CMD_SEEK: begin
              if (CmpW'(q_item_i.seek_position) < CmpW'(eff_len_i)) begin
                pos_d = {IntW'(q_item_i.seek_position), {FRAC_BITS{1'b0}}};
              end else begin
                pos_d = '0;
              end
            end
            default: ;
          endcase
        end
      end
      ST_READ1:  state_d = ST_INTERP;
      ST_INTERP: state_d = ST_VOL;
      ST_VOL:    state_d = ST_BASE;
      ST_BASE:   state_d = ST_PAN;
      ST_PAN:    state_d = ST_FINISH;
      ST_FINISH: begin
        mix_l = sat16(sum_l);
        mix_r = sat16(sum_r);
        if (out_free) begin
          load    = 1'b1;
          pos_d   = pos_q + PosW'(cfg_i.step_rate);
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_d.mix_out_left   = mix_l;
    out_d.mix_out_right  = mix_r;
    out_d.is_playing     = play_d;
    out_d.position_index = 17'(pos_d[PosW-1:FRAC_BITS]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pos_q       <= '0;
      play_q      <= 1'b0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      state_q <= state_d;
      pos_q   <= pos_d;
      play_q  <= play_d;
      if (load) begin
        out_valid_q <= 1'b1;
        out_q       <= out_d;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      cur_q <= q_item_i;
      i1_q  <= AddrW'(i1_next);
    end
    if (state_q == ST_READ1) begin
      s0_q <= $signed(ram_rdata);
    end
    if (state_q == ST_INTERP) begin
      interp_q <= interp_d;
    end
    if (state_q == ST_VOL) begin
      vprod_q <= interp_q * vol_s;
    end
    if (state_q == ST_BASE) begin
      base_q <= vsum[32 +: BaseW];
    end
    if (state_q == ST_PAN) begin
      gprod_q <= base_q * gain_s;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

@@ hdl/resampling_voice_mixer_unit.sv @@
// one sample playback voice with linear interpolation. words enter a two-entry
// command queue and are carried out one at a time by the execution sequencer;
// a sample write, start, stop, seek, an idle or frozen frame, or a frame that
// reaches the end of the sound is done in the idle state, and a playing frame
// walks the sequencer states (two reads of the sample store, interpolation,
// volume, truncation, pan gain, mix and saturation). result words sit in an
// output register, so the queue keeps filling while a result is stalled. the
// sample store has no reset and must be written before it is played.
`include "resampling_voice_mixer_unit_assert.svh"

module resampling_voice_mixer_unit #(
  parameter int SAMPLE_DEPTH = rvm_pkg::RVM_SAMPLE_DEPTH,
  parameter int FRAC_BITS    = rvm_pkg::RVM_FRAC_BITS
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  rvm_pkg::in_item_t               in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output rvm_pkg::out_item_t              out_data_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [1:0]                      cfg_index_i,
  input  logic [rvm_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import rvm_pkg::*;

  localparam int LenW = $clog2(SAMPLE_DEPTH + 1);

  logic [STEP_W-1:0]  step_q;
  logic [16:0]        volume_q;
  logic [7:0]         pan_q;
  logic [16:0]        len_q;

  logic signed [7:0]  pan_sat;
  logic [6:0]         pan_mag;
  voice_cfg_t         voice_cfg;
  logic [LenW-1:0]    eff_len;

  logic               q_valid;
  cmd_item_t          q_item;
  bk_status_t         bk_status;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q   <= STEP_W'(32'h10000);
      volume_q <= UNITY_GAIN;
      pan_q    <= '0;
      len_q    <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_STEP_RATE: step_q   <= cfg_data_i[STEP_W-1:0];
        CFG_VOLUME:    volume_q <= cfg_data_i[16:0];
        CFG_PAN:       pan_q    <= cfg_data_i[7:0];
        CFG_LENGTH:    len_q    <= cfg_data_i[16:0];
        default: ;
      endcase
    end
  end

  // pan clamps to +-100, gain of the far side from the table
  always_comb begin
    if ($signed(pan_q) > PAN_LIMIT) begin
      pan_sat = PAN_LIMIT;
    end else if ($signed(pan_q) < -PAN_LIMIT) begin
      pan_sat = -PAN_LIMIT;
    end else begin
      pan_sat = $signed(pan_q);
    end
    pan_mag = pan_sat[7] ? 7'(-pan_sat) : 7'(pan_sat);
  end

  assign voice_cfg.step_rate = step_q;
  assign voice_cfg.volume    = (volume_q > UNITY_GAIN) ? UNITY_GAIN : volume_q;
  assign voice_cfg.gain      = GAIN_TABLE[pan_mag];
  assign voice_cfg.far_left  = (pan_sat > 8'sd0);

  assign eff_len = (32'(len_q) > 32'(SAMPLE_DEPTH)) ? LenW'(SAMPLE_DEPTH) : LenW'(len_q);

  rvm_front #(
    .SAMPLE_DEPTH (SAMPLE_DEPTH)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .status_i   (bk_status),
    .q_valid_o  (q_valid),
    .q_item_o   (q_item)
  );

  rvm_back #(
    .SAMPLE_DEPTH (SAMPLE_DEPTH),
    .FRAC_BITS    (FRAC_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_item_i    (q_item),
    .status_o    (bk_status),
    .cfg_i       (voice_cfg),
    .eff_len_i   (eff_len),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  `RVM_ASSERT_NOW(a_pop_needs_entry, clk_i, rst_ni, bk_status.pop, q_valid)
  `RVM_ASSERT_NOW(a_busy_no_pop, clk_i, rst_ni, bk_status.busy, !bk_status.pop)
  `RVM_ASSERT_NEXT(a_accept_fills_queue, clk_i, rst_ni, in_valid_i && !in_stall_o, q_valid)

endmodule
